[rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Shared shorthand for the concurrent checks of the occlusion block.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define EGB_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("occlusion check: same-cycle implication failed");

// Next-cycle implication, disabled while reset is low.
`define EGB_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("occlusion check: next-cycle implication failed");

// Condition that must hold in the cycle after a reset cycle.
`define EGB_ASSERT_RST(lbl, clk, rst_n, cons) \
    lbl: assert property (@(posedge clk) !(rst_n) |=> (cons)) \
        else $error("occlusion check: post-reset condition failed");

`endif

[rtl/egobox_pkg.sv]
// ----------------------------------------------------------------------------
// Ego box occlusion package
// Widths, stream layout, register indexes and item kinds shared by the block.
// ----------------------------------------------------------------------------
package egobox_pkg;

    localparam int POS_W           = 32;          // Q16.16 position
    localparam int DIF_W           = POS_W + 1;   // difference of two positions
    localparam int NUM_W           = POS_W + 2;   // slab numerator
    localparam int W_W             = 17;          // coverage weight
    localparam int CAM_W           = 3;           // camera index field
    localparam int CNT_W           = 4;           // camera_count register
    localparam int NSLOT           = 3;
    localparam int NAX             = 3;
    localparam int MAX_CAMERAS_DEF = 8;
    localparam int FRAC_BITS_DEF   = 16;

    // Input tdata layout, lowest bit first.
    localparam int IN_LOAD_LSB  = 0;
    localparam int IN_PT_LSB    = IN_LOAD_LSB + CAM_W;
    localparam int IN_CAM_LSB   = IN_PT_LSB + NAX * POS_W;
    localparam int IN_W_LSB     = IN_CAM_LSB + NSLOT * CAM_W;
    localparam int IN_USED_W    = IN_W_LSB + NSLOT * W_W;
    localparam int IN_DATA_W    = ((IN_USED_W + 7) / 8) * 8;
    localparam int OUT_USED_W   = NSLOT * W_W;
    localparam int OUT_DATA_W   = ((OUT_USED_W + 7) / 8) * 8;

    localparam int REG_IDX_W    = 3;
    typedef logic [REG_IDX_W-1:0] t_reg_idx;
    localparam t_reg_idx REG_CENTER_X = 3'd0;
    localparam t_reg_idx REG_CENTER_Y = 3'd1;
    localparam t_reg_idx REG_CENTER_Z = 3'd2;
    localparam t_reg_idx REG_HALF_X   = 3'd3;
    localparam t_reg_idx REG_HALF_Y   = 3'd4;
    localparam t_reg_idx REG_HALF_Z   = 3'd5;
    localparam t_reg_idx REG_CAM_CNT  = 3'd6;

    localparam logic MODE_LOAD = 1'b0;
    localparam logic MODE_TEST = 1'b1;

endpackage

[rtl/egobox_div.sv]
// ----------------------------------------------------------------------------
// Slab parameter divider
// Pipelined restoring divider: (num << FRAC_BITS) / den, truncated toward
// zero, with the magnitude saturated once it no longer fits FRAC_BITS + 2 bits.
// ----------------------------------------------------------------------------
module egobox_div #(
    parameter int FRAC_BITS = egobox_pkg::FRAC_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_en,
    input  logic signed [egobox_pkg::NUM_W-1:0] i_num,
    input  logic signed [egobox_pkg::DIF_W-1:0] i_den,
    output logic signed [FRAC_BITS+2:0]         o_quo
);

    localparam int QW = FRAC_BITS + 2;
    localparam int RW = egobox_pkg::NUM_W + FRAC_BITS;

    logic [egobox_pkg::NUM_W-1:0] mag_n;
    logic [egobox_pkg::DIF_W-1:0] mag_d;
    logic                         sat;

    logic [RW-1:0]                  r_rem [QW+1];
    logic [egobox_pkg::DIF_W-1:0]   r_dv  [QW+1];
    logic [QW-1:0]                  r_q   [QW+1];
    logic                           r_neg [QW+1];
    logic                           r_sat [QW+1];
    logic [QW-1:0]                  mag_q;

    assign mag_n = i_num[egobox_pkg::NUM_W-1] ? -i_num : i_num;
    assign mag_d = i_den[egobox_pkg::DIF_W-1] ? -i_den : i_den;
    // The quotient reaches 2^QW exactly when |num| >= 4 |den|.
    assign sat   = (egobox_pkg::DIF_W+2)'(mag_n) >= {mag_d, 2'b00};

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= RW'(mag_n) << FRAC_BITS;
            r_dv[0]  <= mag_d;
            r_q[0]   <= '0;
            r_neg[0] <= i_num[egobox_pkg::NUM_W-1] ^ i_den[egobox_pkg::DIF_W-1];
            r_sat[0] <= sat;
        end
    end

    for (genvar k = 0; k < QW; k++) begin : g_bit
        localparam int B = QW - 1 - k;
        logic [RW-1:0] c_shf;
        logic          c_ge;

        assign c_shf = RW'(r_dv[k]) << B;
        assign c_ge  = r_rem[k] >= c_shf;

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k+1] <= c_ge ? (r_rem[k] - c_shf) : r_rem[k];
                r_dv[k+1]  <= r_dv[k];
                r_q[k+1]   <= r_q[k] | (QW'(c_ge) << B);
                r_neg[k+1] <= r_neg[k];
                r_sat[k+1] <= r_sat[k];
            end
        end
    end

    assign mag_q = r_sat[QW] ? '1 : r_q[QW];
    assign o_quo = r_neg[QW] ? -$signed({1'b0, mag_q}) : $signed({1'b0, mag_q});

endmodule

[rtl/ego_box_occlusion_test.sv]
// ----------------------------------------------------------------------------
// Ego box occlusion test
// Zeroes each coverage weight whose camera-to-vertex segment hits the ego box.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake                 Carries
// s (in)    in         i_s_tvalid / o_s_tready   camera load or vertex item
// m (out)   out        o_m_tvalid / i_m_tready   three weights per vertex item
// cfg       in         i_cfg_valid / o_cfg_ready register index and data
//
// One item enters per cycle unless the output is held. A vertex item passes
// three front stages, the FRAC_BITS + 3 stages of the slab dividers and two
// back stages before its result is shown.
// Camera load items write the per-slot camera tables and give no result.
// A stalled output freezes the whole pipeline; nothing is dropped or repeated.
// Reset clears the configuration registers and the valid bits; the camera tables stay as is.
// ----------------------------------------------------------------------------
module ego_box_occlusion_test #(
    parameter int MAX_CAMERAS = egobox_pkg::MAX_CAMERAS_DEF,
    parameter int FRAC_BITS   = egobox_pkg::FRAC_BITS_DEF
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_s_tvalid,
    output logic                                    o_s_tready,
    // load_index, point_x, point_y, point_z, slot_a/b/c_camera,
    // slot_a/b/c_weight, zero padding
    input  logic [egobox_pkg::IN_DATA_W-1:0]        i_s_tdata,
    // mode
    input  logic                                    i_s_tuser,
    output logic                                    o_m_tvalid,
    input  logic                                    i_m_tready,
    // out_weight_a, out_weight_b, out_weight_c, zero padding
    output logic [egobox_pkg::OUT_DATA_W-1:0]       o_m_tdata,
    input  logic                                    i_cfg_valid,
    output logic                                    o_cfg_ready,
    input  logic [egobox_pkg::REG_IDX_W-1:0]        i_cfg_index,
    input  logic [egobox_pkg::POS_W-1:0]            i_cfg_data
);

    localparam int POS_W = egobox_pkg::POS_W;
    localparam int DIF_W = egobox_pkg::DIF_W;
    localparam int NUM_W = egobox_pkg::NUM_W;
    localparam int W_W   = egobox_pkg::W_W;
    localparam int CAM_W = egobox_pkg::CAM_W;
    localparam int NSLOT = egobox_pkg::NSLOT;
    localparam int NAX   = egobox_pkg::NAX;
    localparam int QW    = FRAC_BITS + 2;
    localparam int T_W   = QW + 1;
    localparam int LAT   = QW + 1;
    localparam int CIW   = (MAX_CAMERAS > 1) ? $clog2(MAX_CAMERAS) : 1;
    localparam logic signed [T_W-1:0] T_ONE = {2'b00, 1'b1, {FRAC_BITS{1'b0}}};

    typedef struct packed {
        logic                            valid;
        logic [NSLOT-1:0][W_W-1:0]       w;
        logic [NSLOT-1:0]                en;
        logic [NSLOT-1:0]                pf;
        logic [NSLOT-1:0][NAX-1:0]       dz;
    } t_side;

    // Configuration registers
    logic signed [POS_W-1:0]           r_ctr  [NAX];
    logic signed [POS_W-1:0]           r_half [NAX];
    logic [egobox_pkg::CNT_W-1:0]      r_cam_cnt;

    // Input unpacking
    logic                              s_mode;
    logic [CAM_W-1:0]                  s_load_idx;
    logic [POS_W-1:0]                  s_pt  [NAX];
    logic [CAM_W-1:0]                  s_cam [NSLOT];
    logic [W_W-1:0]                    s_w   [NSLOT];
    logic                              en;
    logic                              s_acc;
    logic                              ld_we;
    logic [CIW-1:0]                    ld_addr;
    logic                              test_on;

    // Pipeline registers
    logic                              r1_valid;
    logic signed [POS_W-1:0]           r1_vtx [NAX];
    logic signed [POS_W-1:0]           r1_cam [NSLOT][NAX];
    logic [W_W-1:0]                    r1_w   [NSLOT];
    logic [NSLOT-1:0]                  r1_en;

    logic                              r2_valid;
    logic signed [DIF_W-1:0]           r2_d [NSLOT][NAX];
    logic signed [DIF_W-1:0]           r2_o [NSLOT][NAX];
    logic [W_W-1:0]                    r2_w [NSLOT];
    logic [NSLOT-1:0]                  r2_en;

    logic                              r3_valid;
    logic signed [NUM_W-1:0]           r3_n1 [NSLOT][NAX];
    logic signed [NUM_W-1:0]           r3_n2 [NSLOT][NAX];
    logic signed [DIF_W-1:0]           r3_d  [NSLOT][NAX];
    logic [NSLOT-1:0][NAX-1:0]         r3_dz;
    logic [NSLOT-1:0]                  r3_pf;
    logic [W_W-1:0]                    r3_w  [NSLOT];
    logic [NSLOT-1:0]                  r3_en;

    logic signed [NUM_W-1:0]           c_o    [NSLOT][NAX];
    logic signed [NUM_W-1:0]           c_h    [NAX];
    logic [NSLOT-1:0][NAX-1:0]         c_dz;
    logic [NSLOT-1:0]                  c_pf;

    t_side                             r_side [LAT];
    t_side                             side_o;
    logic signed [T_W-1:0]             q1 [NSLOT][NAX];
    logic signed [T_W-1:0]             q2 [NSLOT][NAX];
    logic signed [T_W-1:0]             c_lo   [NSLOT];
    logic signed [T_W-1:0]             c_hi   [NSLOT];
    logic signed [T_W-1:0]             c_tmin [NSLOT][NAX];
    logic signed [T_W-1:0]             c_tmax [NSLOT][NAX];
    logic [NSLOT-1:0]                  c_miss;

    logic                              r4_valid;
    logic [W_W-1:0]                    r4_w [NSLOT];
    logic [NSLOT-1:0]                  r4_en;
    logic [NSLOT-1:0]                  r4_miss;

    logic                              r_out_valid;
    logic [W_W-1:0]                    r_out_w [NSLOT];

    // ------------------------------------------------------------------
    // Configuration
    // ------------------------------------------------------------------
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int a = 0; a < NAX; a++) begin
                r_ctr[a]  <= '0;
                r_half[a] <= '0;
            end
            r_cam_cnt <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                egobox_pkg::REG_CENTER_X: r_ctr[0]  <= i_cfg_data;
                egobox_pkg::REG_CENTER_Y: r_ctr[1]  <= i_cfg_data;
                egobox_pkg::REG_CENTER_Z: r_ctr[2]  <= i_cfg_data;
                egobox_pkg::REG_HALF_X:   r_half[0] <= i_cfg_data;
                egobox_pkg::REG_HALF_Y:   r_half[1] <= i_cfg_data;
                egobox_pkg::REG_HALF_Z:   r_half[2] <= i_cfg_data;
                egobox_pkg::REG_CAM_CNT:  r_cam_cnt <= i_cfg_data[egobox_pkg::CNT_W-1:0];
                default: ;
            endcase
        end
    end

    assign test_on = (r_half[0] > 0) || (r_half[1] > 0) || (r_half[2] > 0);

    // ------------------------------------------------------------------
    // Input side
    // ------------------------------------------------------------------
    assign s_mode     = i_s_tuser;
    assign s_load_idx = i_s_tdata[egobox_pkg::IN_LOAD_LSB +: CAM_W];
    for (genvar a = 0; a < NAX; a++) begin : g_pt
        assign s_pt[a] = i_s_tdata[egobox_pkg::IN_PT_LSB + a*POS_W +: POS_W];
    end
    for (genvar s = 0; s < NSLOT; s++) begin : g_slot_in
        assign s_cam[s] = i_s_tdata[egobox_pkg::IN_CAM_LSB + s*CAM_W +: CAM_W];
        assign s_w[s]   = i_s_tdata[egobox_pkg::IN_W_LSB + s*W_W +: W_W];
    end

    // The whole pipeline moves together unless the output item is held.
    assign en         = !r_out_valid || i_m_tready;
    assign o_s_tready = en;
    assign s_acc      = i_s_tvalid && en;
    assign ld_we      = s_acc && (s_mode == egobox_pkg::MODE_LOAD)
                        && (int'(s_load_idx) < MAX_CAMERAS);
    assign ld_addr    = CIW'(s_load_idx);

    // Each slot has its own copy of the camera table so that all three
    // slots are read in the same cycle.
    for (genvar s = 0; s < NSLOT; s++) begin : g_cam_mem
        logic [NAX*POS_W-1:0] mem [MAX_CAMERAS];
        logic [CIW-1:0]       rd_addr;

        assign rd_addr = CIW'(s_cam[s]);

        always_ff @(posedge i_clk) begin
            if (ld_we) begin
                mem[ld_addr] <= {s_pt[2], s_pt[1], s_pt[0]};
            end
            if (en) begin
                for (int a = 0; a < NAX; a++) begin
                    r1_cam[s][a] <= mem[rd_addr][a*POS_W +: POS_W];
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: capture vertex and slot enables
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else if (en) begin
            r1_valid <= s_acc && (s_mode == egobox_pkg::MODE_TEST);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int a = 0; a < NAX; a++) begin
                r1_vtx[a] <= s_pt[a];
            end
            for (int s = 0; s < NSLOT; s++) begin
                r1_w[s]  <= s_w[s];
                r1_en[s] <= test_on && (s_w[s] != '0)
                            && ({1'b0, s_cam[s]} < r_cam_cnt)
                            && (int'(s_cam[s]) < MAX_CAMERAS);
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: direction and camera offset
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_valid <= 1'b0;
        end else if (en) begin
            r2_valid <= r1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int s = 0; s < NSLOT; s++) begin
                for (int a = 0; a < NAX; a++) begin
                    r2_d[s][a] <= DIF_W'(r1_vtx[a]) - DIF_W'(r1_cam[s][a]);
                    r2_o[s][a] <= DIF_W'(r1_cam[s][a]) - DIF_W'(r_ctr[a]);
                end
                r2_w[s] <= r1_w[s];
            end
            r2_en <= r1_en;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: slab numerators and the parallel-axis rule
    // ------------------------------------------------------------------
    always_comb begin
        for (int a = 0; a < NAX; a++) begin
            c_h[a] = NUM_W'(r_half[a]);
        end
        for (int s = 0; s < NSLOT; s++) begin
            c_pf[s] = 1'b0;
            for (int a = 0; a < NAX; a++) begin
                c_o[s][a]  = NUM_W'(r2_o[s][a]);
                c_dz[s][a] = (r2_d[s][a] == '0);
                if (c_dz[s][a] && ((c_o[s][a] < -c_h[a]) || (c_o[s][a] > c_h[a]))) begin
                    c_pf[s] = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_valid <= 1'b0;
        end else if (en) begin
            r3_valid <= r2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int s = 0; s < NSLOT; s++) begin
                for (int a = 0; a < NAX; a++) begin
                    r3_n1[s][a] <= -c_h[a] - c_o[s][a];
                    r3_n2[s][a] <= c_h[a] - c_o[s][a];
                    // A zero direction has no slab; divide by one and ignore it.
                    r3_d[s][a]  <= c_dz[s][a] ? DIF_W'(1) : r2_d[s][a];
                end
                r3_w[s] <= r2_w[s];
            end
            r3_dz <= c_dz;
            r3_pf <= c_pf;
            r3_en <= r2_en;
        end
    end

    // ------------------------------------------------------------------
    // Divider bank, with the item's other fields riding alongside
    // ------------------------------------------------------------------
    for (genvar s = 0; s < NSLOT; s++) begin : g_div_s
        for (genvar a = 0; a < NAX; a++) begin : g_div_a
            egobox_div #(.FRAC_BITS(FRAC_BITS)) u_div_t1 (
                .i_clk (i_clk),
                .i_en  (en),
                .i_num (r3_n1[s][a]),
                .i_den (r3_d[s][a]),
                .o_quo (q1[s][a])
            );
            egobox_div #(.FRAC_BITS(FRAC_BITS)) u_div_t2 (
                .i_clk (i_clk),
                .i_en  (en),
                .i_num (r3_n2[s][a]),
                .i_den (r3_d[s][a]),
                .o_quo (q2[s][a])
            );
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < LAT; k++) begin
                r_side[k] <= '0;
            end
        end else if (en) begin
            r_side[0].valid <= r3_valid;
            for (int s = 0; s < NSLOT; s++) begin
                r_side[0].w[s] <= r3_w[s];
            end
            r_side[0].en <= r3_en;
            r_side[0].pf <= r3_pf;
            r_side[0].dz <= r3_dz;
            for (int k = 1; k < LAT; k++) begin
                r_side[k] <= r_side[k-1];
            end
        end
    end

    assign side_o = r_side[LAT-1];

    // ------------------------------------------------------------------
    // Stage 4: intersect the slab intervals with [0, 1]
    // ------------------------------------------------------------------
    always_comb begin
        for (int s = 0; s < NSLOT; s++) begin
            c_lo[s] = '0;
            c_hi[s] = T_ONE;
            for (int a = 0; a < NAX; a++) begin
                c_tmin[s][a] = (q1[s][a] < q2[s][a]) ? q1[s][a] : q2[s][a];
                c_tmax[s][a] = (q1[s][a] < q2[s][a]) ? q2[s][a] : q1[s][a];
                if (!side_o.dz[s][a]) begin
                    if (c_tmin[s][a] > c_lo[s]) begin
                        c_lo[s] = c_tmin[s][a];
                    end
                    if (c_tmax[s][a] < c_hi[s]) begin
                        c_hi[s] = c_tmax[s][a];
                    end
                end
            end
            c_miss[s] = (c_lo[s] > c_hi[s]) || side_o.pf[s];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_valid <= 1'b0;
        end else if (en) begin
            r4_valid <= side_o.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int s = 0; s < NSLOT; s++) begin
                r4_w[s] <= side_o.w[s];
            end
            r4_en   <= side_o.en;
            r4_miss <= c_miss;
        end
    end

    // ------------------------------------------------------------------
    // Stage 5: output register
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= r4_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int s = 0; s < NSLOT; s++) begin
                r_out_w[s] <= (r4_en[s] && !r4_miss[s]) ? '0 : r4_w[s];
            end
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {{(egobox_pkg::OUT_DATA_W - egobox_pkg::OUT_USED_W){1'b0}},
                         r_out_w[2], r_out_w[1], r_out_w[0]};

endmodule

[rtl/egobox_chk.sv]
// ----------------------------------------------------------------------------
// Ego box occlusion port checker
// Watches the top-level ports for output stalls, backpressure, padding and reset.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module egobox_chk (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    o_s_tready,
    input  logic                                    o_m_tvalid,
    input  logic                                    i_m_tready,
    input  logic [egobox_pkg::OUT_DATA_W-1:0]       o_m_tdata
);

    // A held output item keeps its weights until it is taken.
    `EGB_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_m_tvalid && !i_m_tready, o_m_tvalid && $stable(o_m_tdata))

    // The pipeline freezes while its result is held, so no item may enter.
    `EGB_ASSERT_IMP(a_backpressure, i_clk, i_rst_n, o_m_tvalid && !i_m_tready, !o_s_tready)

    // The padding above the three weights is always zero.
    `EGB_ASSERT_IMP(a_pad_zero, i_clk, i_rst_n, o_m_tvalid, o_m_tdata[egobox_pkg::OUT_DATA_W-1:egobox_pkg::OUT_USED_W] == '0)

    // No result is shown right after reset.
    `EGB_ASSERT_RST(a_reset_empty, i_clk, i_rst_n, !o_m_tvalid)

endmodule

bind ego_box_occlusion_test egobox_chk u_egobox_chk (.*);

[tb/tb.sv]
// ----------------------------------------------------------------------------
// Ego box occlusion testbench
// Loads the camera table, sweeps the box registers through several settings
// and streams vertex items under varying idle and stall patterns. A predictor
// of the slab test computes the expected weights for every vertex item; each
// output item is compared field by field with the oldest expected entry.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;

    localparam int POS_W       = egobox_pkg::POS_W;
    localparam int W_W         = egobox_pkg::W_W;
    localparam int CAM_W       = egobox_pkg::CAM_W;
    localparam int CNT_W       = egobox_pkg::CNT_W;
    localparam int NSLOT       = egobox_pkg::NSLOT;
    localparam int NAX         = egobox_pkg::NAX;
    localparam int IN_DATA_W   = egobox_pkg::IN_DATA_W;
    localparam int OUT_DATA_W  = egobox_pkg::OUT_DATA_W;
    localparam int REG_IDX_W   = egobox_pkg::REG_IDX_W;
    localparam int MAX_CAMS    = egobox_pkg::MAX_CAMERAS_DEF;
    localparam int FRAC_BITS   = egobox_pkg::FRAC_BITS_DEF;
    localparam int LATENCY     = FRAC_BITS + 7;
    localparam int CYCLE_LIMIT = 400000;

    typedef struct {
        logic [CAM_W-1:0]        load_idx;
        logic signed [POS_W-1:0] pt [NAX];
        logic [CAM_W-1:0]        cam [NSLOT];
        logic [W_W-1:0]          wt [NSLOT];
    } t_vertex_item;

    typedef struct {
        logic [W_W-1:0] wt [NSLOT];
    } t_weights;

    logic                    i_clk;
    logic                    i_rst_n;
    logic                    i_s_tvalid;
    logic                    o_s_tready;
    logic [IN_DATA_W-1:0]    i_s_tdata;
    logic                    i_s_tuser;
    logic                    o_m_tvalid;
    logic                    i_m_tready;
    logic [OUT_DATA_W-1:0]   o_m_tdata;
    logic                    i_cfg_valid;
    logic                    o_cfg_ready;
    logic [REG_IDX_W-1:0]    i_cfg_index;
    logic [POS_W-1:0]        i_cfg_data;

    // Predictor state
    logic signed [POS_W-1:0] box_ctr [NAX];
    logic signed [POS_W-1:0] box_half [NAX];
    logic [CNT_W-1:0]        cam_count;
    logic signed [POS_W-1:0] cam_table [MAX_CAMS][NAX];

    t_weights expected_weights [$];
    int       errors;
    int       cycles;
    int       send_idle_pct;
    int       recv_stall_pct;
    int       hold_left;

    ego_box_occlusion_test dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb: done, errors");
            $finish;
        end
    end

    // Closed segment from camera to vertex against the box, slab method.
    function automatic bit segment_blocked(longint cam [NAX], longint vtx [NAX]);
        longint one;
        longint lo;
        longint hi;
        longint d;
        longint o;
        longint h;
        longint t1;
        longint t2;
        longint tmp;
        one = 64'sd1 <<< FRAC_BITS;
        lo  = 0;
        hi  = one;
        for (int ax = 0; ax < NAX; ax++) begin
            d = vtx[ax] - cam[ax];
            o = cam[ax] - longint'(box_ctr[ax]);
            h = longint'(box_half[ax]);
            if (d == 0) begin
                if (o < -h || o > h) return 1'b0;
                continue;
            end
            t1 = ((-h - o) * one) / d;
            t2 = ((h - o) * one) / d;
            if (t1 > t2) begin
                tmp = t1;
                t1  = t2;
                t2  = tmp;
            end
            if (t1 > lo) lo = t1;
            if (t2 < hi) hi = t2;
            if (lo > hi) return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic t_weights occluded_weights(t_vertex_item v);
        t_weights r;
        bit       enabled;
        longint   cam [NAX];
        longint   vtx [NAX];
        enabled = box_half[0] > 0 || box_half[1] > 0 || box_half[2] > 0;
        for (int ax = 0; ax < NAX; ax++) vtx[ax] = longint'(v.pt[ax]);
        for (int s = 0; s < NSLOT; s++) begin
            r.wt[s] = v.wt[s];
            if (enabled && v.wt[s] != 0 && v.cam[s] < cam_count) begin
                for (int ax = 0; ax < NAX; ax++) cam[ax] = longint'(cam_table[v.cam[s]][ax]);
                if (segment_blocked(cam, vtx)) r.wt[s] = '0;
            end
        end
        return r;
    endfunction

    function automatic logic [IN_DATA_W-1:0] pack_item(t_vertex_item v);
        logic [IN_DATA_W-1:0] d;
        d = '0;
        d[egobox_pkg::IN_LOAD_LSB +: CAM_W] = v.load_idx;
        for (int ax = 0; ax < NAX; ax++) begin
            d[egobox_pkg::IN_PT_LSB + ax*POS_W +: POS_W] = v.pt[ax];
        end
        for (int s = 0; s < NSLOT; s++) begin
            d[egobox_pkg::IN_CAM_LSB + s*CAM_W +: CAM_W] = v.cam[s];
            d[egobox_pkg::IN_W_LSB + s*W_W +: W_W]       = v.wt[s];
        end
        return d;
    endfunction

    // Caller is at a falling edge; returns at a falling edge with valid still high.
    task automatic send_item(logic mode, t_vertex_item v);
        while ($urandom_range(99) < send_idle_pct) begin
            i_s_tvalid = 1'b0;
            @(negedge i_clk);
        end
        i_s_tvalid = 1'b1;
        i_s_tuser  = mode;
        i_s_tdata  = pack_item(v);
        do @(posedge i_clk); while (!o_s_tready);
        if (mode == egobox_pkg::MODE_LOAD) begin
            for (int ax = 0; ax < NAX; ax++) cam_table[v.load_idx][ax] = v.pt[ax];
        end else begin
            expected_weights = {expected_weights, occluded_weights(v)};
        end
        @(negedge i_clk);
    endtask

    task automatic write_reg(egobox_pkg::t_reg_idx idx, logic [POS_W-1:0] value);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = value;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            egobox_pkg::REG_CENTER_X: box_ctr[0]  = value;
            egobox_pkg::REG_CENTER_Y: box_ctr[1]  = value;
            egobox_pkg::REG_CENTER_Z: box_ctr[2]  = value;
            egobox_pkg::REG_HALF_X:   box_half[0] = value;
            egobox_pkg::REG_HALF_Y:   box_half[1] = value;
            egobox_pkg::REG_HALF_Z:   box_half[2] = value;
            egobox_pkg::REG_CAM_CNT:  cam_count   = value[CNT_W-1:0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task automatic set_box(logic [POS_W-1:0] cx, logic [POS_W-1:0] cy, logic [POS_W-1:0] cz,
                           logic [POS_W-1:0] hx, logic [POS_W-1:0] hy, logic [POS_W-1:0] hz,
                           logic [POS_W-1:0] cnt);
        write_reg(egobox_pkg::REG_CENTER_X, cx);
        write_reg(egobox_pkg::REG_CENTER_Y, cy);
        write_reg(egobox_pkg::REG_CENTER_Z, cz);
        write_reg(egobox_pkg::REG_HALF_X, hx);
        write_reg(egobox_pkg::REG_HALF_Y, hy);
        write_reg(egobox_pkg::REG_HALF_Z, hz);
        write_reg(egobox_pkg::REG_CAM_CNT, cnt);
    endtask

    // Camera loads give no output, so extra cycles let the pipe empty fully.
    task automatic drain;
        i_s_tvalid = 1'b0;
        while (expected_weights.size() != 0) @(negedge i_clk);
        repeat (LATENCY + 8) @(negedge i_clk);
    endtask

    function automatic logic signed [POS_W-1:0] rand_pos();
        int sel;
        sel = $urandom_range(99);
        if (sel < 70) return $signed($urandom_range(0, 32'h0010_0000)) - 32'sh0008_0000;
        if (sel < 85) return $signed($urandom_range(0, 32'h0006_0000)) - 32'sh0003_0000;
        return $urandom;
    endfunction

    function automatic logic [W_W-1:0] rand_weight();
        int sel;
        sel = $urandom_range(99);
        if (sel < 15) return '0;
        if (sel < 25) return 17'h10000;
        if (sel < 35) return W_W'($urandom_range(17'h1FFFF, 17'h10001));
        return W_W'($urandom_range(17'hFFFF, 1));
    endfunction

    function automatic t_vertex_item rand_item();
        t_vertex_item v;
        v.load_idx = CAM_W'($urandom_range(MAX_CAMS - 1));
        for (int ax = 0; ax < NAX; ax++) v.pt[ax] = rand_pos();
        for (int s = 0; s < NSLOT; s++) begin
            v.cam[s] = CAM_W'($urandom_range(MAX_CAMS - 1));
            v.wt[s]  = rand_weight();
        end
        return v;
    endfunction

    function automatic t_vertex_item make_vertex(int x, int y, int z, logic [2:0] ca,
                                                 logic [2:0] cb, logic [2:0] cc,
                                                 logic [W_W-1:0] w);
        t_vertex_item v;
        v = '{load_idx: 3'd0, pt: '{x, y, z}, cam: '{ca, cb, cc}, wt: '{w, w, w}};
        return v;
    endfunction

    // Receiver: stalls at random, or holds off for a counted stretch.
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            hold_left--;
            i_m_tready = 1'b0;
        end else begin
            i_m_tready = ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        t_weights       exp_w;
        logic [W_W-1:0] got;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (expected_weights.size() == 0) begin
                $error("unexpected output item %h", o_m_tdata);
                errors++;
            end else begin
                exp_w = expected_weights.pop_front();
                for (int s = 0; s < NSLOT; s++) begin
                    got = o_m_tdata[s*W_W +: W_W];
                    if (got !== exp_w.wt[s]) begin
                        $error("out_weight_%s: expected %h, got %h",
                               s == 0 ? "a" : s == 1 ? "b" : "c", exp_w.wt[s], got);
                        errors++;
                    end
                end
            end
        end
    end

    task automatic test_directed;
        t_vertex_item v;
        // Fill the whole camera table, extremes included.
        for (int c = 0; c < MAX_CAMS; c++) begin
            v = make_vertex(-32'sh0004_0000 + c * 32'sh0000_1000, 0, 0, 0, 0, 0, 0);
            v.load_idx = CAM_W'(c);
            if (c == 6) v.pt = '{32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF};
            if (c == 7) v.pt = '{32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000};
            send_item(egobox_pkg::MODE_LOAD, v);
        end
        drain();
        set_box(0, 0, 0, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 8);
        send_item(egobox_pkg::MODE_TEST, make_vertex(32'sh0004_0000, 0, 0, 0, 1, 2, 17'h0FFFF));
        send_item(egobox_pkg::MODE_TEST, make_vertex(32'sh0004_0000, 32'sh0003_0000, 0,
                                                     0, 1, 2, 17'h10000));
        // Zero direction on y and z: inside and outside the slab.
        send_item(egobox_pkg::MODE_TEST, make_vertex(32'sh0004_0000, 0, 0, 0, 0, 0, 17'h1FFFF));
        send_item(egobox_pkg::MODE_TEST, make_vertex(32'sh0004_0000, 0, 32'sh0000_0000,
                                                     1, 2, 3, 17'h1));
        send_item(egobox_pkg::MODE_TEST, make_vertex(32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
                                                     32'sh7FFF_FFFF, 6, 7, 0, 17'h08000));
        send_item(egobox_pkg::MODE_TEST, make_vertex(32'sh8000_0000, 32'sh8000_0000,
                                                     32'sh8000_0000, 6, 7, 0, 17'h08000));
        send_item(egobox_pkg::MODE_TEST, make_vertex(32'sh0000_8000, 0, 0, 0, 4, 5, 17'h0));
        // Vertex that stops short of the box.
        send_item(egobox_pkg::MODE_TEST, make_vertex(-32'sh0002_0000, 0, 0, 0, 1, 2,
                                                     17'h00100));
        drain();
        // Slots at or above the camera count are left alone.
        set_box(0, 0, 32'h0000_0000, 32'h0001_0000, 32'hFFFF_0000, 32'h0001_0000, 3);
        send_item(egobox_pkg::MODE_TEST, make_vertex(32'sh0004_0000, 0, 0, 0, 3, 7, 17'h0ABCD));
        send_item(egobox_pkg::MODE_TEST, make_vertex(32'sh0004_0000, 32'sh0000_8000, 0,
                                                     1, 2, 5, 17'h12345));
        drain();
        // All half extents at or below zero disables the test.
        set_box(0, 0, 0, 0, 32'hFFFF_FFFF, 32'h8000_0000, 8);
        send_item(egobox_pkg::MODE_TEST, make_vertex(32'sh0004_0000, 0, 0, 0, 1, 2, 17'h04000));
        drain();
        write_reg(egobox_pkg::REG_CAM_CNT, 0);
        send_item(egobox_pkg::MODE_TEST, make_vertex(32'sh0004_0000, 0, 0, 0, 1, 2, 17'h04000));
        drain();
    endtask

    task automatic test_random(int count, int idle_pct, int stall_pct);
        t_vertex_item v;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        for (int n = 0; n < count; n++) begin
            v = rand_item();
            send_item(($urandom_range(99) < 10) ? egobox_pkg::MODE_LOAD : egobox_pkg::MODE_TEST,
                      v);
        end
        drain();
    endtask

    task automatic test_backpressure;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_left      = 400;
        for (int n = 0; n < 120; n++) send_item(egobox_pkg::MODE_TEST, rand_item());
        drain();
    endtask

    initial begin
        errors         = 0;
        cycles         = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_left      = 0;
        i_rst_n        = 1'b0;
        i_s_tvalid     = 1'b0;
        i_s_tuser      = egobox_pkg::MODE_LOAD;
        i_s_tdata      = '0;
        i_m_tready     = 1'b0;
        i_cfg_valid    = 1'b0;
        i_cfg_index    = egobox_pkg::REG_CENTER_X;
        i_cfg_data     = '0;
        box_ctr        = '{0, 0, 0};
        box_half       = '{0, 0, 0};
        cam_count      = '0;
        repeat (8) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        test_directed();
        set_box(0, 0, 0, 32'h0002_0000, 32'h0002_0000, 32'h0002_0000, 8);
        test_random(160, 0, 0);
        set_box(32'h0001_0000, 32'hFFFF_0000, 32'h0000_8000,
                32'h0003_0000, 32'h0001_0000, 32'hFFFF_0000, 6);
        test_random(140, 69, 0);
        set_box(32'h8000_0000, 32'h7FFF_FFFF, 0,
                32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 8);
        test_random(140, 0, 69);
        set_box(0, 32'h0000_4000, 0, 32'h0001_8000, 32'h0002_8000, 32'h0001_0000, 4);
        test_random(140, 7, 7);
        set_box(0, 0, 0, 32'h0002_0000, 32'h0001_0000, 32'h0003_0000, 8);
        test_backpressure();

        if (errors == 0) begin
            $display("tb: done, clean");
        end else begin
            $display("tb: done, errors");
        end
        $finish;
    end
endmodule
